// ===== rtl/core/rtqs_pkg.sv =====
// Shared types and constants for the radio transmit queue scheduler.
// No dependencies; imported by every module of the core but rtqs_ram.
package rtqs_pkg;

    localparam int QUEUE_DEPTH = 8;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W       = CNT_W + 1;
    localparam int SLOT_W      = 6;

    localparam int IN_DATA_W   = 160;
    localparam int OUT_DATA_W  = 96;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 19;

    localparam int MAX_FRAME_LEN      = 255;
    localparam int WATCHDOG_MARGIN_MS = 100;
    localparam logic signed [7:0] POWER_FLOOR = -8'sd126;

    localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
    localparam logic [1:0] FUNC_PUMP    = 2'd1;
    localparam logic [1:0] FUNC_ARM     = 2'd2;
    localparam logic [1:0] FUNC_COLLECT = 2'd3;

    localparam logic [2:0] KIND_QUEUED   = 3'd0;
    localparam logic [2:0] KIND_TOO_LONG = 3'd1;
    localparam logic [2:0] KIND_FULL     = 3'd2;
    localparam logic [2:0] KIND_START    = 3'd3;
    localparam logic [2:0] KIND_EXPIRED  = 3'd4;
    localparam logic [2:0] KIND_FAILED   = 3'd5;
    localparam logic [2:0] KIND_AIRED    = 3'd6;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd7;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPREADING = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BANDWIDTH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CODING    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PREAMBLE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_POWER     = 3'd4;

    typedef struct packed {
        logic [3:0]         pad;
        logic [2:0]         radio_code;
        logic [31:0]        time_arg;
        logic [9:0]         frame_len;
        logic [15:0]        frame_seq;
        logic [7:0]         frame_tag;
        logic signed [7:0]  power_req;
        logic signed [16:0] preamble_req;
        logic signed [4:0]  cr_req;
        logic signed [19:0] bw_req;
        logic signed [4:0]  sf_req;
        logic [31:0]        now_ms;
    } rtqs_in_t;

    typedef struct packed {
        logic [3:0]        pad;
        logic [2:0]        fail_code;
        logic [5:0]        out_slot;
        logic [7:0]        out_len;
        logic signed [7:0] out_power_dbm;
        logic [15:0]       out_preamble;
        logic [3:0]        out_cr;
        logic [18:0]       out_bw_hz;
        logic [3:0]        out_sf;
        logic [15:0]       out_seq;
        logic [7:0]        out_tag;
    } rtqs_out_t;

    typedef struct packed {
        logic [31:0]       deadline;
        logic [7:0]        len;
        logic [15:0]       seq;
        logic [7:0]        tag;
        logic signed [7:0] power;
        logic [15:0]       preamble;
        logic [3:0]        cr;
        logic [18:0]       bw;
        logic [3:0]        sf;
    } rtqs_entry_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } rtqs_cmd_t;

    typedef struct packed {
        logic emit;
        logic out_free;
    } rtqs_status_t;

endpackage

// ===== rtl/core/rtqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rtqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/rtqs_ctrl.sv =====
// Item sequencer: takes an item, waits for the head read, commits when the
// result register can take the outcome. Depends on rtqs_pkg.
module rtqs_ctrl import rtqs_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  rtqs_status_t st,
    output rtqs_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!st.emit || st.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/core/rtqs_dp.sv =====
// Datapath: default registers, frame ring, in-flight/watchdog state and the
// result register. Depends on rtqs_pkg and rtqs_ram.
module rtqs_dp import rtqs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [1:0]            s_tuser,
    input  logic                  cfg_valid,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  rtqs_cmd_t             cmd,
    output rtqs_status_t          st,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [2:0]            m_tuser
);

    logic [3:0]        def_sf_reg;
    logic [18:0]       def_bw_reg;
    logic [3:0]        def_cr_reg;
    logic [15:0]       def_pre_reg;
    logic signed [7:0] def_pw_reg;

    rtqs_in_t   item_reg;
    logic [1:0] func_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      drop_count_reg, drop_count_next;
    logic             awaiting_reg, awaiting_next;
    logic             inflight_valid_reg, inflight_valid_next;
    logic [27:0]      inflight_ident_reg, inflight_ident_next;
    logic [31:0]      watchdog_reg, watchdog_next;
    logic [31:0]      timeout_count_reg, timeout_count_next;
    logic [31:0]      failed_count_reg, failed_count_next;

    logic             m_tvalid_reg;
    rtqs_out_t        m_tdata_reg;
    logic [2:0]       m_tuser_reg;

    rtqs_entry_t      head_entry;
    rtqs_entry_t      new_entry;
    logic [IDX_W-1:0] tail;
    logic [SUM_W-1:0] tail_sum;
    logic [IDX_W-1:0] head_inc;
    logic [33:0]      wd_sum;
    logic [31:0]      wd_sat;
    logic             ram_we;
    logic             emit;
    rtqs_out_t        res;
    logic [2:0]       res_kind;

    rtqs_ram #(
        .WIDTH ($bits(rtqs_entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we & cmd.commit),
        .waddr (tail),
        .wdata (new_entry),
        .re    (cmd.capture),
        .raddr (head_reg),
        .rdata (head_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            def_sf_reg  <= 4'd7;
            def_bw_reg  <= 19'd125000;
            def_cr_reg  <= 4'd5;
            def_pre_reg <= 16'd8;
            def_pw_reg  <= 8'sd14;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_SPREADING: def_sf_reg  <= cfg_data[3:0];
                CFG_BANDWIDTH: def_bw_reg  <= cfg_data;
                CFG_CODING:    def_cr_reg  <= cfg_data[3:0];
                CFG_PREAMBLE:  def_pre_reg <= cfg_data[15:0];
                CFG_POWER:     def_pw_reg  <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_tdata;
            func_reg <= s_tuser;
        end
    end

    // enqueue: settings left unset take the defaults
    always_comb begin
        new_entry.deadline = item_reg.time_arg;
        new_entry.len      = item_reg.frame_len[7:0];
        new_entry.seq      = item_reg.frame_seq;
        new_entry.tag      = item_reg.frame_tag;
        new_entry.sf       = item_reg.sf_req[4] ? def_sf_reg : item_reg.sf_req[3:0];
        new_entry.bw       = item_reg.bw_req[19] ? def_bw_reg : item_reg.bw_req[18:0];
        new_entry.cr       = item_reg.cr_req[4] ? def_cr_reg : item_reg.cr_req[3:0];
        new_entry.preamble = item_reg.preamble_req[16] ? def_pre_reg
                                                       : item_reg.preamble_req[15:0];
        new_entry.power    = (item_reg.power_req < POWER_FLOOR) ? def_pw_reg
                                                                 : item_reg.power_req;
    end

    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (tail_sum >= SUM_W'(QUEUE_DEPTH))
                    ? IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign wd_sum = {2'b00, item_reg.now_ms} + {2'b00, item_reg.time_arg}
                  + {3'b000, item_reg.time_arg[31:1]} + 34'(WATCHDOG_MARGIN_MS);
    assign wd_sat = (|wd_sum[33:32]) ? '1 : wd_sum[31:0];

    always_comb begin
        head_next           = head_reg;
        count_next          = count_reg;
        drop_count_next     = drop_count_reg;
        awaiting_next       = awaiting_reg;
        inflight_valid_next = inflight_valid_reg;
        inflight_ident_next = inflight_ident_reg;
        watchdog_next       = watchdog_reg;
        timeout_count_next  = timeout_count_reg;
        failed_count_next   = failed_count_reg;
        ram_we              = 1'b0;
        emit                = 1'b0;
        res                 = '0;
        res_kind            = KIND_QUEUED;
        case (func_reg)
            FUNC_ENQUEUE: begin
                emit        = 1'b1;
                res.out_tag = item_reg.frame_tag;
                res.out_seq = item_reg.frame_seq;
                if (item_reg.frame_len > 10'(MAX_FRAME_LEN)) begin
                    res_kind = KIND_TOO_LONG;
                end else if (count_reg >= CNT_W'(QUEUE_DEPTH)) begin
                    res_kind        = KIND_FULL;
                    drop_count_next = drop_count_reg + 32'd1;
                end else begin
                    res_kind     = KIND_QUEUED;
                    res.out_sf   = new_entry.sf;
                    res.out_slot = SLOT_W'(tail);
                    ram_we       = 1'b1;
                    count_next   = count_reg + 1'b1;
                end
            end
            FUNC_PUMP: begin
                if (!item_reg.radio_code[0] && count_reg != '0 && !awaiting_reg) begin
                    emit        = 1'b1;
                    res.out_tag = head_entry.tag;
                    res.out_seq = head_entry.seq;
                    res.out_sf  = head_entry.sf;
                    if (head_entry.deadline != '0
                        && item_reg.now_ms >= head_entry.deadline) begin
                        res_kind   = KIND_EXPIRED;
                        head_next  = head_inc;
                        count_next = count_reg - 1'b1;
                    end else begin
                        res_kind          = KIND_START;
                        res.out_bw_hz     = head_entry.bw;
                        res.out_cr        = head_entry.cr;
                        res.out_preamble  = head_entry.preamble;
                        res.out_power_dbm = head_entry.power;
                        res.out_len       = head_entry.len;
                        res.out_slot      = SLOT_W'(head_reg);
                        awaiting_next     = 1'b1;
                    end
                end
            end
            FUNC_ARM: begin
                awaiting_next = 1'b0;
                if (awaiting_reg && count_reg != '0) begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                    if (item_reg.radio_code == '0) begin
                        inflight_ident_next = {head_entry.sf, head_entry.seq, head_entry.tag};
                        inflight_valid_next = 1'b1;
                        watchdog_next       = wd_sat;
                    end else begin
                        emit              = 1'b1;
                        res_kind          = KIND_FAILED;
                        res.out_tag       = head_entry.tag;
                        res.out_seq       = head_entry.seq;
                        res.out_sf        = head_entry.sf;
                        res.fail_code     = item_reg.radio_code;
                        failed_count_next = failed_count_reg + 32'd1;
                    end
                end
            end
            FUNC_COLLECT: begin
                if (item_reg.radio_code[1]
                    || (item_reg.radio_code[0] && item_reg.now_ms > watchdog_reg)) begin
                    if (item_reg.radio_code[1]) begin
                        res_kind = KIND_AIRED;
                    end else begin
                        res_kind           = KIND_TIMEOUT;
                        timeout_count_next = timeout_count_reg + 32'd1;
                    end
                    emit                = inflight_valid_reg;
                    res.out_tag         = inflight_ident_reg[7:0];
                    res.out_seq         = inflight_ident_reg[23:8];
                    res.out_sf          = inflight_ident_reg[27:24];
                    inflight_valid_next = 1'b0;
                    watchdog_next       = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg           <= '0;
            count_reg          <= '0;
            drop_count_reg     <= '0;
            awaiting_reg       <= 1'b0;
            inflight_valid_reg <= 1'b0;
            inflight_ident_reg <= '0;
            watchdog_reg       <= '0;
            timeout_count_reg  <= '0;
            failed_count_reg   <= '0;
        end else if (cmd.commit) begin
            head_reg           <= head_next;
            count_reg          <= count_next;
            drop_count_reg     <= drop_count_next;
            awaiting_reg       <= awaiting_next;
            inflight_valid_reg <= inflight_valid_next;
            inflight_ident_reg <= inflight_ident_next;
            watchdog_reg       <= watchdog_next;
            timeout_count_reg  <= timeout_count_next;
            failed_count_reg   <= failed_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit && emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit && emit) begin
            m_tdata_reg <= res;
            m_tuser_reg <= res_kind;
        end
    end

    // emit above out_free
    assign st = {emit, !m_tvalid_reg || m_tready};

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/core/radio_tx_queue_scheduler_core.sv =====
// Top level of the radio transmit queue scheduler core.
// Depends on rtqs_pkg, rtqs_ctrl and rtqs_dp.
//
//  port group  | dir | carries
//  ------------+-----+------------------------------------------------
//  s_*         | in  | request item: func in tuser, fields in tdata
//  m_*         | out | outcome item: kind in tuser, fields in tdata
//  cfg_*       | in  | default register writes, index in cfg_addr
//
// Each item is taken in ST_IDLE, where the ring head is read from the frame
// RAM, and committed in ST_EXEC, which updates state and loads the result
// register. The result register holds an outcome while the next item is
// taken; an item that produces an outcome waits in ST_EXEC while that
// register is still full. Reset is synchronous; the ring holds no valid
// state until written and needs no clearing. cfg_ready is always high.
module radio_tx_queue_scheduler_core import rtqs_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_ms, sf_req, bw_req, cr_req, preamble_req, power_req, frame_tag,
    // frame_seq, frame_len, time_arg, radio_code, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func
    input  logic [1:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_tag, out_seq, out_sf, out_bw_hz, out_cr, out_preamble,
    // out_power_dbm, out_len, out_slot, fail_code, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind
    output logic [2:0]            m_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rtqs_cmd_t    cmd;
    rtqs_status_t st;

    assign cfg_ready = 1'b1;

    rtqs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rtqs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .st        (st),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
